// ----- design/cfd_pkg.sv -----
`default_nettype none
package cfd_pkg;

   localparam int MAX_PAYLOAD = 512;
   localparam int IDX_W = $clog2(MAX_PAYLOAD);
   localparam int ADDR_W = IDX_W + 1;
   localparam int LEN_W = 10;
   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

   localparam logic [7:0] CRC_POLY = 8'h07;

   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   localparam logic [2:0] OUT_NONE = 3'd0;
   localparam logic [2:0] OUT_HELD = 3'd1;
   localparam logic [2:0] OUT_BUSY = 3'd2;
   localparam logic [2:0] OUT_CRC_BAD = 3'd3;
   localparam logic [2:0] OUT_END_BAD = 3'd4;
   localparam logic [2:0] OUT_LEN_LARGE = 3'd5;

   localparam logic [1:0] REG_START_ONE = 2'd0;
   localparam logic [1:0] REG_START_TWO = 2'd1;
   localparam logic [1:0] REG_END = 2'd2;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- design/crc8_frame_deframer.sv -----
`default_nettype none
// Frame parser for a byte link: start byte one, start byte two, command, 16-bit little-endian
// length, payload, CRC-8 (poly 0x07, init 0, over command, length and payload), end byte.
// Each request carries an action in req_tuser: a line byte, a read of a held payload byte by
// index, or a release of the held frame. One request is taken every clock cycle unless
// responses stall, and each yields exactly one response, registered in the s1 stage with the
// registered RAM read, then in the s2 output register. The RAM holds two payload banks: the
// parser fills one while a good frame that was taken sits in the other, and taking a frame
// swaps the banks, so no payload is copied. Payload RAM contents are not cleared after reset.
module crc8_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // line_byte[7:0], read_index[16:8]
   input  wire logic [1:0]  req_tuser,  // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // outcome[2:0], held_valid[3], held_command[11:4], held_length[21:12], read_data[29:22]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SOF, PH_CMD, PH_LENLO, PH_LENHI, PH_DATA, PH_CRC, PH_END
   } phase_type;

   typedef struct packed {
      logic [2:0]                    outcome;
      logic                          held_valid;
      logic [7:0]                    held_command;
      logic [cfd_pkg::LEN_W-1:0]     held_length;
      logic                          rd_use;
   } stage_type;

   phase_type phase_ff, phase_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] lenlo_ff, lenlo_in;
   logic [cfd_pkg::LEN_W-1:0] len_ff, len_in;
   logic [cfd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] rcrc_ff, rcrc_in;
   logic bank_ff, bank_in;
   logic [7:0] held_cmd_ff, held_cmd_in;
   logic [cfd_pkg::LEN_W-1:0] held_len_ff, held_len_in;
   logic held_flag_ff, held_flag_in;
   logic [7:0] sb1_ff, sb1_in, sb2_ff, sb2_in, end_ff, end_in;

   logic s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic s2_valid_ff, s2_valid_in;
   logic [31:0] s2_data_ff, s2_data_in;

   cfd_pkg::ram_wr_type ram_wr;
   cfd_pkg::ram_rd_type ram_rd;
   logic [7:0] ram_q;

   logic accept;
   logic s2_load;
   logic [1:0] action;
   logic [7:0] line_byte;
   logic [cfd_pkg::IDX_W-1:0] read_index;
   logic [15:0] full_len;
   logic [cfd_pkg::CNT_W-1:0] count_next;

   assign action = req_tuser;
   assign line_byte = req_tdata[7:0];
   assign read_index = req_tdata[16:8];

   assign s2_load = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign full_len = {line_byte, lenlo_ff};
   assign count_next = count_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      cmd_in = cmd_ff;
      lenlo_in = lenlo_ff;
      len_in = len_ff;
      count_in = count_ff;
      crc_in = crc_ff;
      rcrc_in = rcrc_ff;
      bank_in = bank_ff;
      held_cmd_in = held_cmd_ff;
      held_len_in = held_len_ff;
      held_flag_in = held_flag_ff;
      s1_in = s1_ff;
      ram_wr.en = 1'b0;
      ram_wr.addr = {bank_ff, count_ff[cfd_pkg::IDX_W-1:0]};
      ram_wr.data = line_byte;
      ram_rd.en = 1'b0;
      ram_rd.addr = {~bank_ff, read_index};

      if (accept) begin
         s1_in.outcome = cfd_pkg::OUT_NONE;
         s1_in.rd_use = 1'b0;
         case (action)
            cfd_pkg::ACT_BYTE: begin
               case (phase_ff)
                  PH_IDLE: begin
                     if (line_byte == sb1_ff) begin
                        phase_in = PH_SOF;
                     end
                  end
                  PH_SOF: begin
                     phase_in = (line_byte == sb2_ff) ? PH_CMD : PH_IDLE;
                  end
                  PH_CMD: begin
                     cmd_in = line_byte;
                     crc_in = cfd_pkg::crc8_step(8'h00, line_byte);
                     phase_in = PH_LENLO;
                  end
                  PH_LENLO: begin
                     lenlo_in = line_byte;
                     crc_in = cfd_pkg::crc8_step(crc_ff, line_byte);
                     phase_in = PH_LENHI;
                  end
                  PH_LENHI: begin
                     len_in = full_len[cfd_pkg::LEN_W-1:0];
                     crc_in = cfd_pkg::crc8_step(crc_ff, line_byte);
                     count_in = '0;
                     if (full_len > 16'(cfd_pkg::MAX_PAYLOAD)) begin
                        phase_in = PH_IDLE;
                        s1_in.outcome = cfd_pkg::OUT_LEN_LARGE;
                     end else if (full_len == 16'd0) begin
                        phase_in = PH_CRC;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     ram_wr.en = 1'b1;
                     crc_in = cfd_pkg::crc8_step(crc_ff, line_byte);
                     count_in = count_next;
                     // count and length share one width
                     if (count_next >= len_ff) begin
                        phase_in = PH_CRC;
                     end
                  end
                  PH_CRC: begin
                     rcrc_in = line_byte;
                     phase_in = PH_END;
                  end
                  PH_END: begin
                     if (line_byte != end_ff) begin
                        s1_in.outcome = cfd_pkg::OUT_END_BAD;
                     end else if (crc_ff != rcrc_ff) begin
                        s1_in.outcome = cfd_pkg::OUT_CRC_BAD;
                     end else if (held_flag_ff) begin
                        s1_in.outcome = cfd_pkg::OUT_BUSY;
                     end else begin
                        held_cmd_in = cmd_ff;
                        held_len_in = len_ff;
                        held_flag_in = 1'b1;
                        bank_in = ~bank_ff;
                        s1_in.outcome = cfd_pkg::OUT_HELD;
                     end
                     phase_in = PH_IDLE;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
            cfd_pkg::ACT_READ: begin
               ram_rd.en = 1'b1;
               s1_in.rd_use = held_flag_ff && ({1'b0, read_index} < held_len_ff);
            end
            cfd_pkg::ACT_RELEASE: begin
               held_flag_in = 1'b0;
            end
            default: ;
         endcase
         s1_in.held_valid = held_flag_in;
         s1_in.held_command = held_flag_in ? held_cmd_in : 8'h00;
         s1_in.held_length = held_flag_in ? held_len_in : '0;
      end
   end

   always_comb begin
      sb1_in = sb1_ff;
      sb2_in = sb2_ff;
      end_in = end_ff;
      if (csr_valid) begin
         case (csr_index)
            cfd_pkg::REG_START_ONE: sb1_in = csr_data;
            cfd_pkg::REG_START_TWO: sb2_in = csr_data;
            cfd_pkg::REG_END: end_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      s2_valid_in = s2_load ? 1'b1 : (rsp_tready ? 1'b0 : s2_valid_ff);
      s2_data_in = s2_data_ff;
      if (s2_load) begin
         s2_data_in = {2'b00, (s1_ff.rd_use ? ram_q : 8'h00), s1_ff.held_length,
                       s1_ff.held_command, s1_ff.held_valid, s1_ff.outcome};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bank_ff <= 1'b0;
         held_flag_ff <= 1'b0;
         sb1_ff <= 8'hAA;
         sb2_ff <= 8'h55;
         end_ff <= 8'h0D;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bank_ff <= bank_in;
         held_flag_ff <= held_flag_in;
         sb1_ff <= sb1_in;
         sb2_ff <= sb2_in;
         end_ff <= end_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      lenlo_ff <= lenlo_in;
      len_ff <= len_in;
      count_ff <= count_in;
      crc_ff <= crc_in;
      rcrc_ff <= rcrc_in;
      held_cmd_ff <= held_cmd_in;
      held_len_ff <= held_len_in;
      s1_ff <= s1_in;
      s2_data_ff <= s2_data_in;
   end

   cfd_payload_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata = s2_data_ff;

endmodule
`default_nettype wire

// ----- design/cfd_payload_ram.sv -----
`default_nettype none
module cfd_payload_ram (
   input  wire logic                clock,
   input  wire cfd_pkg::ram_wr_type wr,
   input  wire cfd_pkg::ram_rd_type rd,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [2*cfd_pkg::MAX_PAYLOAD];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read data only moves on a read, so a stalled result keeps its byte
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule
`default_nettype wire

// ----- design/cfd_checker.sv -----
`default_nettype none
module cfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [1:0]  csr_index,
   input wire logic [7:0]  csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_tvalid, req_tready, req_tdata, req_tuser,
                        csr_valid, csr_ready, csr_index, csr_data};

   // a stalled response holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= cfd_pkg::OUT_LEN_LARGE)
      else $error("outcome code out of range");

   // nothing held means no held fields and no read byte
   a_empty_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[21:4] == 18'd0 && rsp_tdata[29:22] == 8'd0)
      else $error("held fields shown with no frame held");

   a_taken_is_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == cfd_pkg::OUT_HELD |-> rsp_tdata[3])
      else $error("frame taken but slot not marked held");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind crc8_frame_deframer cfd_checker u_cfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);
`default_nettype wire
